/* hw/rtl/hsv2rgb_pkg.sv */
// Shared types for the HSV to RGB converter: item structs and stage enables.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // One HSV pixel as it enters the converter.
    typedef struct packed {
        logic [16:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_pixel_t;

    // One RGB pixel as it leaves the converter.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } rgb_pixel_t;

    // Load enables for the four pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } hsv2rgb_stage_en_t;

endpackage

/* hw/rtl/hsv2rgb_datapath.sv */
// Four-stage arithmetic datapath of the HSV to RGB converter.
`timescale 1ns / 1ps

module hsv2rgb_datapath (
    input  logic                          clk,
    input  hsv2rgb_pkg::hsv2rgb_stage_en_t en,
    input  hsv2rgb_pkg::hsv_pixel_t        pix,
    output hsv2rgb_pkg::rgb_pixel_t        rgb
);
    import hsv2rgb_pkg::*;

    // Reciprocal of 15 scaled by 2^19, rounded up; exact for 15-bit dividends.
    localparam logic [15:0] RECIP_15   = 16'd34953;
    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [16:0] WIDE_SCALE = 17'd65280;
    localparam logic [8:0]  FRAC_ONE   = 9'd256;

    localparam logic [3:0] SECTOR_RED     = 4'd0;
    localparam logic [3:0] SECTOR_YELLOW  = 4'd1;
    localparam logic [3:0] SECTOR_GREEN   = 4'd2;
    localparam logic [3:0] SECTOR_CYAN    = 4'd3;
    localparam logic [3:0] SECTOR_BLUE    = 4'd4;

    // Exact floor(y / 255) for any y up to 65279, where the quotient fits 8 bits.
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] acc;
        acc = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
        return acc[15:8];
    endfunction

    // Stage 1: hue / 60, taken as (hue >> 2) / 15 by reciprocal.
    logic [30:0] h_prod;
    logic [11:0] h60_reg;
    logic [7:0]  sat1_reg, val1_reg;

    assign h_prod = {16'd0, pix.hue[16:2]} * {15'd0, RECIP_15};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            h60_reg  <= h_prod[30:19];
            sat1_reg <= pix.saturation;
            val1_reg <= pix.brightness;
        end
    end

    // Stage 2: sector and fraction, the three narrow products.
    logic [3:0]  sector;
    logic [7:0]  frac;
    logic [15:0] sf_prod, pm_prod;
    logic [16:0] st_prod;
    logic [15:0] qa_next, ta_next;
    logic [15:0] qa_reg, ta_reg, pm_reg;
    logic [3:0]  sector2_reg;
    logic [7:0]  val2_reg;
    logic        szero2_reg;

    assign sector  = h60_reg[11:8];
    assign frac    = h60_reg[7:0];
    assign sf_prod = {8'd0, sat1_reg} * {8'd0, frac};
    assign st_prod = {9'd0, sat1_reg} * {8'd0, FRAC_ONE - {1'b0, frac}};
    assign pm_prod = {8'd0, val1_reg} * {8'd0, FULL_SCALE - sat1_reg};
    assign qa_next = 16'(WIDE_SCALE - {1'b0, sf_prod});
    assign ta_next = 16'(WIDE_SCALE - st_prod);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            qa_reg      <= qa_next;
            ta_reg      <= ta_next;
            pm_reg      <= pm_prod;
            sector2_reg <= sector;
            val2_reg    <= val1_reg;
            szero2_reg  <= (sat1_reg == 8'd0);
        end
    end

    // Stage 3: scale the q and t terms by value, finish p.
    logic [23:0] qm_prod, tm_prod;
    logic [23:0] qm_reg, tm_reg;
    logic [7:0]  p3_reg, val3_reg;
    logic [3:0]  sector3_reg;
    logic        szero3_reg;

    assign qm_prod = {16'd0, val2_reg} * {8'd0, qa_reg};
    assign tm_prod = {16'd0, val2_reg} * {8'd0, ta_reg};

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            qm_reg      <= qm_prod;
            tm_reg      <= tm_prod;
            p3_reg      <= div255(pm_reg);
            val3_reg    <= val2_reg;
            sector3_reg <= sector2_reg;
            szero3_reg  <= szero2_reg;
        end
    end

    // Stage 4: divide by 65280 as a shift by 8 then by 255, and steer.
    logic [7:0]  q_val, t_val;
    rgb_pixel_t  rgb_next, rgb_reg;

    assign q_val = div255(qm_reg[23:8]);
    assign t_val = div255(tm_reg[23:8]);

    always_comb
    begin
        if (szero3_reg)
        begin
            rgb_next = '{val3_reg, val3_reg, val3_reg};
        end
        else
        begin
            case (sector3_reg)
                SECTOR_RED:    rgb_next = '{val3_reg, t_val, p3_reg};
                SECTOR_YELLOW: rgb_next = '{q_val, val3_reg, p3_reg};
                SECTOR_GREEN:  rgb_next = '{p3_reg, val3_reg, t_val};
                SECTOR_CYAN:   rgb_next = '{p3_reg, q_val, val3_reg};
                SECTOR_BLUE:   rgb_next = '{t_val, p3_reg, val3_reg};
                // Magenta sector, and hues beyond the circle.
                default:       rgb_next = '{val3_reg, p3_reg, q_val};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

/* hw/rtl/hsv_to_rgb_converter_unit.sv */
// Top level of the HSV to RGB converter: handshakes and pipeline valid chain.
`timescale 1ns / 1ps

// Channel  Valid      Ready      Payload  Item
// -------  ---------  ---------  -------  ---------------------------------
// input    hsv_valid  hsv_ready  hsv      hue, saturation, brightness
// output   rgb_valid  rgb_ready  rgb      red_out, green_out, blue_out
//
// Each item passes through four register stages in turn, and its result is on
// the output once it reaches the last of them; one item can be taken every
// cycle unless the input is held off as described below.
// Stage 4 is the output register. Reset clears only the stage valid bits.
// When the output is stalled, empty stages still fill; the input is held off
// only once all four stages carry an item, and nothing is dropped or doubled.

module hsv_to_rgb_converter_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hsv_valid,
    output logic                    hsv_ready,
    input  hsv2rgb_pkg::hsv_pixel_t hsv,
    output logic                    rgb_valid,
    input  logic                    rgb_ready,
    output hsv2rgb_pkg::rgb_pixel_t rgb
);
    import hsv2rgb_pkg::*;

    // One valid bit per stage; an item moves forward whenever the next
    // stage is empty or is itself moving on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    hsv2rgb_stage_en_t en;

    always_comb
    begin
        en.s4 = !v4_reg || rgb_ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign hsv_ready = en.s1;
    assign rgb_valid = v4_reg;

    always_comb
    begin
        v1_next = en.s1 ? hsv_valid : v1_reg;
        v2_next = en.s2 ? v1_reg    : v2_reg;
        v3_next = en.s3 ? v2_reg    : v3_reg;
        v4_next = en.s4 ? v3_reg    : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // The arithmetic itself, loaded by the same stage enables.
    hsv2rgb_datapath u_datapath (
        .clk (clk),
        .en  (en),
        .pix (hsv),
        .rgb (rgb)
    );

`ifndef ASSERT_OFF
    // The input is refused only when every stage holds an item and the
    // output is stalled.
    a_refuse_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !rgb_ready))
        else $error("input refused while the pipeline has room");

    // An accepted item always occupies the first stage afterwards.
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv_ready) |=> v1_reg)
        else $error("accepted item lost at the first stage");

    // A delivered result with nothing behind it leaves the output empty.
    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb_ready && !v3_reg) |=> !rgb_valid)
        else $error("result repeated or invented at the output");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for the HSV to RGB converter, with its own colour predictor.
`timescale 1ns / 1ps

// What is tested and how:
// A predictor of our own works out the RGB pixel for every HSV item that the
// converter accepts, and queues it. A single checking process pops the oldest
// prediction for each RGB item that leaves the block and compares the three
// colour channels one by one. A short directed test covers the extremes: grey
// pixels, both ends of each of the six hue sectors, the fraction boundaries
// and hues beyond 360 degrees. Random tests then run in three idling
// patterns: a mostly busy sender with a mostly stalled receiver, the reverse,
// and neither idling. One test holds the receiver off for a long stretch
// while the sender keeps offering items, so that the pipeline fills and the
// block has to stall its input. A watchdog ends the run if nothing moves for
// too long.

module tb;

    import hsv2rgb_pkg::*;

    // Fixed-point scales of the conversion: one sector spans 60 degrees in
    // units of 1/256 degree, and the sector fraction advances every 60 units.
    localparam int unsigned SECTOR_SPAN = 15360;
    localparam int unsigned FRAC_STEP   = 60;
    localparam int unsigned FULL_SCALE  = 255;
    localparam int unsigned WIDE_SCALE  = 65280;
    localparam int unsigned HUE_TOP     = 92159;
    localparam int unsigned HUE_MAX     = 131071;

    // The six hue sectors in order of increasing hue. Anything beyond the
    // last one reuses the magenta-to-red pattern.
    typedef enum int unsigned {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } hue_sector_t;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PRESSURE_HOLD  = 400;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       hsv_valid = 1'b0;
    logic       hsv_ready;
    hsv_pixel_t hsv       = '0;
    logic       rgb_valid;
    logic       rgb_ready = 1'b0;
    rgb_pixel_t rgb;

    // Predicted RGB pixels, oldest first.
    rgb_pixel_t  rgb_expected_q[$];

    // Idle percentages for each side, and a long hold-off for the receiver
    // that its own process counts down.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned receiver_hold     = 0;

    int unsigned error_count    = 0;
    int unsigned pixels_sent    = 0;
    int unsigned pixels_checked = 0;
    int unsigned grey_pixels    = 0;
    int unsigned wrapped_hues   = 0;

    hsv_to_rgb_converter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // The colour predictor. A grey pixel (zero saturation) passes brightness
    // straight through. Otherwise the hue is split into a sector and an 8-bit
    // fraction within it, the three blended levels p, q and t are formed with
    // truncating division, and the sector picks which level goes where.
    function automatic rgb_pixel_t hsv_to_rgb_predict(input hsv_pixel_t px);
        rgb_pixel_t  res;
        int unsigned v;
        int unsigned s;
        int unsigned sector;
        int unsigned frac;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        v = px.brightness;
        s = px.saturation;
        if (s == 0)
        begin
            res.red_out   = 8'(v);
            res.green_out = 8'(v);
            res.blue_out  = 8'(v);
            return res;
        end
        sector = px.hue / SECTOR_SPAN;
        frac   = (px.hue % SECTOR_SPAN) / FRAC_STEP;
        p = (v * (FULL_SCALE - s)) / FULL_SCALE;
        q = (v * (WIDE_SCALE - s * frac)) / WIDE_SCALE;
        t = (v * (WIDE_SCALE - s * (256 - frac))) / WIDE_SCALE;
        case (sector)
            SEC_RED_YELLOW:   res = {8'(v), 8'(t), 8'(p)};
            SEC_YELLOW_GREEN: res = {8'(q), 8'(v), 8'(p)};
            SEC_GREEN_CYAN:   res = {8'(p), 8'(v), 8'(t)};
            SEC_CYAN_BLUE:    res = {8'(p), 8'(q), 8'(v)};
            SEC_BLUE_MAGENTA: res = {8'(t), 8'(p), 8'(v)};
            default:          res = {8'(v), 8'(p), 8'(q)};
        endcase
        return res;
    endfunction

    // Offers one pixel to the converter and returns at the edge where it is
    // accepted. It is always entered at a rising edge, so hsv_valid gets a
    // single update in each time step: either it stays high for the next
    // item or it drops for an idle gap.
    task automatic send_pixel(input hsv_pixel_t px);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            hsv_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv       <= px;
        do
        begin
            @(posedge clk);
        end
        while (!hsv_ready);
        rgb_expected_q.push_back(hsv_to_rgb_predict(px));
        pixels_sent++;
        if (px.saturation == 0)
        begin
            grey_pixels++;
        end
        if (px.hue > HUE_TOP)
        begin
            wrapped_hues++;
        end
    endtask

    function automatic hsv_pixel_t make_pixel(input int unsigned hue_val,
                                              input int unsigned sat_val,
                                              input int unsigned val_val);
        hsv_pixel_t px;
        px.hue        = 17'(hue_val);
        px.saturation = 8'(sat_val);
        px.brightness = 8'(val_val);
        return px;
    endfunction

    // Random pixels: mostly hues inside the circle, some placed right at a
    // sector edge where the fraction is 0 or 255, a few beyond 360 degrees,
    // and a tenth of them grey.
    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t  px;
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(99);
        base = $urandom_range(5) * SECTOR_SPAN;
        if (pick < 8)
        begin
            px.hue = 17'($urandom_range(HUE_MAX, HUE_TOP + 1));
        end
        else if (pick < 20)
        begin
            if ($urandom_range(1) == 0)
            begin
                px.hue = 17'(base + $urandom_range(FRAC_STEP - 1));
            end
            else
            begin
                px.hue = 17'(base + SECTOR_SPAN - 1 - $urandom_range(FRAC_STEP - 1));
            end
        end
        else
        begin
            px.hue = 17'($urandom_range(HUE_TOP));
        end
        px.saturation = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(255));
        px.brightness = 8'($urandom_range(255));
        return px;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count)
        begin
            send_pixel(random_pixel());
        end
    endtask

    // Receiver: either sits out a long hold-off, counted here cycle by cycle,
    // or takes results at random according to its idle percentage.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (receiver_hold > 0)
            begin
                rgb_ready <= 1'b0;
                receiver_hold--;
            end
            else
            begin
                rgb_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Every RGB item that leaves the block is compared with the oldest
    // prediction. A result with nothing predicted is a failure in itself.
    initial
    begin
        rgb_pixel_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rgb_valid && rgb_ready)
            begin
                if (rgb_expected_q.size() == 0)
                begin
                    $error("unexpected RGB item: red %0d green %0d blue %0d",
                           rgb.red_out, rgb.green_out, rgb.blue_out);
                    error_count++;
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    check_channel("red_out", want.red_out, rgb.red_out);
                    check_channel("green_out", want.green_out, rgb.green_out);
                    check_channel("blue_out", want.blue_out, rgb.blue_out);
                    pixels_checked++;
                end
            end
        end
    end

    // Watchdog: any cycle with a handshake on either channel restarts the
    // count, so the limit covers the longest legal stall with a wide margin.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                         quiet, rgb_expected_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Grey pixels, sector starts at full and sector ends at 200 saturation, the
    // first fraction step, hues past 360 degrees and a black pixel with colour.
    task automatic test_directed_extremes();
        int unsigned k;
        send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(0, 0, 255));
        send_pixel(make_pixel(HUE_TOP, 0, 128));
        for (k = 0; k < 6; k++)
        begin
            send_pixel(make_pixel(k * SECTOR_SPAN, 255, 255));
        end
        for (k = 0; k < 6; k++)
        begin
            send_pixel(make_pixel(k * SECTOR_SPAN + SECTOR_SPAN - 1, 200, 255));
        end
        send_pixel(make_pixel(HUE_TOP + 1, 255, 200));
        send_pixel(make_pixel(7 * SECTOR_SPAN, 255, 200));
        send_pixel(make_pixel(8 * SECTOR_SPAN, 128, 200));
        send_pixel(make_pixel(HUE_MAX, 1, 255));
        send_pixel(make_pixel(FRAC_STEP - 1, 1, 255));
        send_pixel(make_pixel(FRAC_STEP, 255, 255));
        send_pixel(make_pixel(12345, 255, 0));
    endtask

    // Busy sender, receiver mostly stalled: results pile up in the pipeline.
    task automatic test_random_slow_receiver();
        sender_idle_pct   = 11;
        receiver_idle_pct = 87;
        run_random(530);
    endtask

    // Sender mostly idle, receiver mostly ready: the pipeline runs nearly empty.
    task automatic test_random_slow_sender();
        sender_idle_pct   = 87;
        receiver_idle_pct = 11;
        run_random(530);
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // items back to back; the four stages fill and the input must stall
    // without losing or repeating anything.
    task automatic test_output_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        receiver_hold     = PRESSURE_HOLD;
        run_random(60);
    endtask

    // Full rate on both sides: one item per cycle in and out.
    task automatic test_random_streaming();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(480);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 11;
        receiver_idle_pct = 87;
        test_directed_extremes();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_output_backpressure();
        test_random_streaming();
        hsv_valid <= 1'b0;

        // Let the last results drain, then give the block time to show any stray
        // output. The watchdog bounds this wait.
        while (rgb_expected_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d pixels and checked %0d results, under three idling patterns",
                 pixels_sent, pixels_checked);
        $display("and one long output stall; %0d grey pixels, %0d hues past 360 degrees.",
                 grey_pixels, wrapped_hues);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
